// File: src/lbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for linear blend skinning
// Field layout of the stream words, the stage enable group and the
// saturation helper used by the blend and transform stages.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int DEF_MAX_BONE_COUNT   = 64;
	localparam int DEF_BONES_PER_VERTEX = 4;
	localparam int DEF_FRAC_BITS        = 16;

	// Fixed field geometry.
	localparam int FIELD_SLOTS = 4;
	localparam int ID_BITS     = 6;
	localparam int WEIGHT_BITS = 16;
	localparam int ELEMS       = 12;   // rows 0..2 of a 4x4 matrix
	localparam int ELEM_IDX_W  = 4;
	localparam int BLEND_ACC_W = 52;
	localparam int XF_ACC_W    = 67;

	// Input tdata layout, lowest bit first.
	localparam int IN_TDATA_W  = 232;
	localparam int OFS_BONE    = 0;
	localparam int OFS_ELEM    = 6;
	localparam int OFS_VALUE   = 10;
	localparam int OFS_PX      = 42;
	localparam int OFS_PY      = 74;
	localparam int OFS_PZ      = 106;
	localparam int OFS_IDS     = 138;
	localparam int OFS_WGT     = 162;
	localparam int OUT_TDATA_W = 96;

	// Function codes carried in tuser.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SKIN = 1'b1;

	typedef logic [ELEMS-1:0][31:0] row_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic        en;
		logic [5:0]  bone;
		logic [3:0]  elem;
		logic [31:0] value;
	} bone_wr_t;

	// Clamp a wide signed value to 32-bit signed.
	function automatic logic signed [31:0] sat32(input logic signed [XF_ACC_W-1:0] v);
		logic signed [XF_ACC_W-1:0] hi_lim;
		logic signed [XF_ACC_W-1:0] lo_lim;
		hi_lim = XF_ACC_W'(32'sh7FFF_FFFF);
		lo_lim = XF_ACC_W'(-33'sd2147483648);
		if (v > hi_lim)
			sat32 = 32'sh7FFF_FFFF;
		else if (v < lo_lim)
			sat32 = 32'sh8000_0000;
		else
			sat32 = v[31:0];
	endfunction

endpackage

// File: src/lbs_bone_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_bone_store: bone matrix memory
// One copy of the matrix rows per bone slot so all slots read in the same
// cycle. Loads write every copy; a clearing pass zeroes it after reset.
// ----------------------------------------------------------------------------
module lbs_bone_store import lbs_pkg::*; #(
	parameter int MAX_BONE_COUNT = DEF_MAX_BONE_COUNT,
	parameter int NSLOT          = FIELD_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bone_wr_t                      wr,
	input  logic [NSLOT-1:0][ID_BITS-1:0] rd_ids,
	input  logic                          rd_en,
	output row_t                          rows_s1 [NSLOT],
	output logic                          busy
);

	localparam int ROW_W = (MAX_BONE_COUNT > 1) ? $clog2(MAX_BONE_COUNT) : 1;

	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_cnt_q;
	logic [8:0]       wr_bone9;
	logic             wr_hit;
	logic [ROW_W-1:0] wr_row;

	// Clearing pass, one row per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ROW_W'(MAX_BONE_COUNT - 1))
				clr_busy_q <= 1'b0;
		end
	end

	assign busy     = clr_busy_q;
	assign wr_bone9 = {3'b000, wr.bone};
	assign wr_row   = wr_bone9[ROW_W-1:0];
	assign wr_hit   = wr.en && (wr_bone9 < 9'(MAX_BONE_COUNT))
		&& (wr.elem < ELEM_IDX_W'(ELEMS));

	for (genvar n = 0; n < NSLOT; n++) begin : g_copy
		row_t       mem [MAX_BONE_COUNT];
		logic [8:0] id9;
		assign id9 = {3'b000, rd_ids[n]};

		// Write port and registered row read.
		always_ff @(posedge clk) begin
			if (clr_busy_q)
				mem[clr_cnt_q] <= '0;
			else if (wr_hit)
				mem[wr_row][wr.elem] <= wr.value;
			if (rd_en)
				rows_s1[n] <= mem[id9[ROW_W-1:0]];
		end
	end

endmodule

// File: src/lbs_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_blend: weighted sum of the bone matrices
// Stage 2 forms weight times element per slot, stage 3 sums the slots,
// rounds half up to the element format and saturates.
// ----------------------------------------------------------------------------
module lbs_blend import lbs_pkg::*; #(
	parameter int NSLOT = FIELD_SLOTS
) (
	input  logic                              clk,
	input  stage_en_t                         en,
	input  row_t                              rows_s1 [NSLOT],
	input  logic [NSLOT-1:0][WEIGHT_BITS-1:0] wgt_s1,
	input  logic [NSLOT-1:0]                  sv_s1,
	output logic [ELEMS-1:0][31:0]            blend_s3
);

	logic signed [48:0]            prod_s2 [NSLOT][ELEMS];
	logic signed [BLEND_ACC_W-1:0] acc [ELEMS];

	// Per-slot products; a slot whose bone is out of use gives zero.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int n = 0; n < NSLOT; n++) begin
				for (int e = 0; e < ELEMS; e++) begin
					if (sv_s1[n])
						prod_s2[n][e] <= $signed({1'b0, wgt_s1[n]})
							* $signed(rows_s1[n][e]);
					else
						prod_s2[n][e] <= '0;
				end
			end
		end
	end

	// Slot sum with the rounding constant.
	always_comb begin
		for (int e = 0; e < ELEMS; e++) begin
			acc[e] = BLEND_ACC_W'(1) <<< (WEIGHT_BITS - 1);
			for (int n = 0; n < NSLOT; n++)
				acc[e] = acc[e] + BLEND_ACC_W'(prod_s2[n][e]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int e = 0; e < ELEMS; e++)
				blend_s3[e] <= sat32(XF_ACC_W'(acc[e] >>> WEIGHT_BITS));
		end
	end

endmodule

// File: src/lbs_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_xform: applies the blended matrix to the position
// Stage 4 forms the nine element-by-coordinate products, stage 5 sums each
// row with the translation, rounds, saturates and selects pass-through.
// ----------------------------------------------------------------------------
module lbs_xform import lbs_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  stage_en_t              en,
	input  logic [ELEMS-1:0][31:0] blend_s3,
	input  logic [2:0][31:0]       pos_s3,
	input  logic                   pass_s3,
	output logic [2:0][31:0]       res_s5
);

	logic signed [63:0]         prod_s4 [3][3];
	logic signed [31:0]         trn_s4  [3];
	logic [2:0][31:0]           pos_s4;
	logic                       pass_s4;
	logic signed [XF_ACC_W-1:0] sum [3];

	// Row-by-coordinate products.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s4[r][c] <= $signed(blend_s3[r*4+c]) * $signed(pos_s3[c]);
				trn_s4[r] <= $signed(blend_s3[r*4+3]);
			end
			pos_s4  <= pos_s3;
			pass_s4 <= pass_s3;
		end
	end

	// Exact row sum with translation scaled by one and the rounding constant.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = (XF_ACC_W'(trn_s4[r]) <<< FRAC_BITS)
				+ (XF_ACC_W'(1) <<< (FRAC_BITS - 1));
			for (int c = 0; c < 3; c++)
				sum[r] = sum[r] + XF_ACC_W'(prod_s4[r][c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int r = 0; r < 3; r++)
				res_s5[r] <= pass_s4 ? pos_s4[r] : sat32(sum[r] >>> FRAC_BITS);
		end
	end

endmodule

// File: src/linear_blend_skinning.sv
`timescale 1ns / 1ps
// A vertex's result is valid on the master side once it has passed stages s1 to s5.
// Throughput: one item per cycle while no result is held and the store is not clearing; loads take no pipeline slot.
// After arst_n releases, the matrix store is zeroed one bone per cycle,
// and s_tready stays low until that pass ends.
// Backpressure stalls only the stages behind a held result; bubbles close up.
// ----------------------------------------------------------------------------
// linear_blend_skinning: four-bone linear blend skinning engine
// Load items fill the bone matrix store; vertex items are blended and
// transformed in a five-stage pipeline with signed Q16.16 results.
// ----------------------------------------------------------------------------
module linear_blend_skinning import lbs_pkg::*; #(
	parameter int MAX_BONE_COUNT   = DEF_MAX_BONE_COUNT,
	parameter int BONES_PER_VERTEX = DEF_BONES_PER_VERTEX,
	parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// bone_sel, elem_sel, elem_value, pos_x, pos_y, pos_z, bone_ids, weights
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]             s_tuser,
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_x, out_y, out_z
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration: bone_count.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [6:0]             cfg_data
);

	localparam int NSLOT = (BONES_PER_VERTEX < FIELD_SLOTS) ? BONES_PER_VERTEX : FIELD_SLOTS;

	logic                              accept;
	logic                              busy;
	logic [6:0]                        bone_count_q;
	logic [8:0]                        limit;
	stage_en_t                         en;
	bone_wr_t                          wr;
	logic [NSLOT-1:0][ID_BITS-1:0]     ids;
	logic [NSLOT-1:0][WEIGHT_BITS-1:0] wgt;
	logic [NSLOT-1:0]                  sv;
	row_t                              rows_s1 [NSLOT];
	logic [NSLOT-1:0][WEIGHT_BITS-1:0] wgt_s1;
	logic [NSLOT-1:0]                  sv_s1;
	logic [ELEMS-1:0][31:0]            blend_s3;
	logic [2:0][31:0]                  pos_s1, pos_s2, pos_s3;
	logic                              pass_s1, pass_s2, pass_s3;
	logic                              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][31:0]                  res_s5;

	// Configuration register; writes are taken in any cycle.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bone_count_q <= '0;
		else if (cfg_valid)
			bone_count_q <= cfg_data;
	end

	// Stage enables: a stage moves when it is empty or the next one moves.
	assign en.s5    = !v_s5 || m_tready;
	assign en.s4    = !v_s4 || en.s5;
	assign en.s3    = !v_s3 || en.s4;
	assign en.s2    = !v_s2 || en.s3;
	assign en.s1    = !v_s1 || en.s2;
	assign s_tready = en.s1 && !busy;
	assign accept   = s_tvalid && s_tready;

	// Load transfer into the store.
	assign wr.en    = accept && (s_tuser[0] == FUNC_LOAD);
	assign wr.bone  = s_tdata[OFS_BONE +: ID_BITS];
	assign wr.elem  = s_tdata[OFS_ELEM +: ELEM_IDX_W];
	assign wr.value = s_tdata[OFS_VALUE +: 32];

	// Slot decode; a bone at or above the bones in use gives a zero matrix.
	assign limit = ({2'b00, bone_count_q} > 9'(MAX_BONE_COUNT))
		? 9'(MAX_BONE_COUNT) : {2'b00, bone_count_q};
	always_comb begin
		for (int n = 0; n < NSLOT; n++) begin
			ids[n] = s_tdata[OFS_IDS + n*ID_BITS +: ID_BITS];
			wgt[n] = s_tdata[OFS_WGT + n*WEIGHT_BITS +: WEIGHT_BITS];
			sv[n]  = {3'b000, ids[n]} < limit;
		end
	end

	lbs_bone_store #(
		.MAX_BONE_COUNT(MAX_BONE_COUNT),
		.NSLOT         (NSLOT)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_ids (ids),
		.rd_en  (en.s1),
		.rows_s1(rows_s1),
		.busy   (busy)
	);

	// Valid bits; only vertex transfers enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= accept && (s_tuser[0] == FUNC_SKIN);
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// Side data that rides along with each vertex.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			wgt_s1  <= wgt;
			sv_s1   <= sv;
			pos_s1  <= {s_tdata[OFS_PZ +: 32], s_tdata[OFS_PY +: 32], s_tdata[OFS_PX +: 32]};
			pass_s1 <= (bone_count_q == 7'd0);
		end
		if (en.s2) begin
			pos_s2  <= pos_s1;
			pass_s2 <= pass_s1;
		end
		if (en.s3) begin
			pos_s3  <= pos_s2;
			pass_s3 <= pass_s2;
		end
	end

	lbs_blend #(
		.NSLOT(NSLOT)
	) u_blend (
		.clk     (clk),
		.en      (en),
		.rows_s1 (rows_s1),
		.wgt_s1  (wgt_s1),
		.sv_s1   (sv_s1),
		.blend_s3(blend_s3)
	);

	lbs_xform #(
		.FRAC_BITS(FRAC_BITS)
	) u_xform (
		.clk     (clk),
		.en      (en),
		.blend_s3(blend_s3),
		.pos_s3  (pos_s3),
		.pass_s3 (pass_s3),
		.res_s5  (res_s5)
	);

	assign m_tvalid = v_s5;
	assign m_tdata  = res_s5;

endmodule

// File: src/lbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_checker: port-level checks for the skinning engine
// Tracks vertex transfers against result transfers and checks that results
// only appear for vertices in flight and never exceed the pipeline depth.
// ----------------------------------------------------------------------------
module lbs_checker import lbs_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [0:0]             s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [3:0] DEPTH = 4'd5;

	logic       vin;
	logic       vout;
	logic [3:0] inflight_q;

	assign vin  = s_tvalid && s_tready && (s_tuser[0] == FUNC_SKIN);
	assign vout = m_tvalid && m_tready;

	// Vertices accepted whose result has not been transferred yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + {3'b000, vin} - {3'b000, vout};
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 4'd0)
		else $error("result without a vertex in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= DEPTH)
		else $error("more vertices in flight than pipeline stages");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == DEPTH && !m_tready |-> !s_tready)
		else $error("input taken with a full stalled pipeline");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_blend_skinning
// Streams bone-matrix loads and vertices through the block under random
// gaps and backpressure, predicts every skinned position from a local
// matrix store and compares it with the master side word by word.
// ----------------------------------------------------------------------------
module tb import lbs_pkg::*; ();

	localparam int NBONES = 64;

	typedef struct {
		logic            func;
		logic [5:0]      bone;
		logic [3:0]      elem;
		logic [31:0]     value;
		logic [31:0]     px, py, pz;
		logic [23:0]     ids;
		logic [63:0]     wgt;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;

	linear_blend_skinning dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Predictor state: the matrix store and the bone count.
	logic [31:0] mat_store [NBONES*16];
	logic [6:0]  bones_used;

	item_t pending_items[$];
	logic [95:0] expected_pos[$];
	int errors = 0;
	int mismatches = 0;
	int vertices_checked = 0;
	longint cycles = 0;
	bit in_gaps = 1'b1;
	bit out_stall = 1'b1;
	bit in_hold = 1'b0;
	bit out_hold = 1'b0;
	logic s_tready_q = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void queue_item(input item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic longint floor_div(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Apply one accepted item to the store or predict its skinned position.
	function automatic void skin_predict(input item_t it);
		longint pos [3];
		longint blend [12];
		longint acc, p, hi;
		logic [63:0] lo;
		logic [95:0] res;
		int lim, id;
		if (it.func == FUNC_LOAD) begin
			mat_store[it.bone*16 + it.elem] = it.value;
			return;
		end
		pos[0] = $signed(it.px);
		pos[1] = $signed(it.py);
		pos[2] = $signed(it.pz);
		if (bones_used == 0) begin
			expected_pos.insert(expected_pos.size(), {it.pz, it.py, it.px});
			return;
		end
		lim = (bones_used > NBONES) ? NBONES : bones_used;
		for (int e = 0; e < 12; e++) begin
			acc = 0;
			for (int n = 0; n < 4; n++) begin
				id = it.ids[6*n +: 6];
				if (id < lim)
					acc += longint'(it.wgt[16*n +: 16]) *
						longint'($signed(mat_store[id*16 + e]));
			end
			blend[e] = $signed(clamp32(floor_div(acc + 32768, 16)));
		end
		for (int r = 0; r < 3; r++) begin
			hi = blend[r*4 + 3];
			lo = 0;
			for (int c = 0; c < 3; c++) begin
				p = blend[r*4 + c] * pos[c];
				hi += floor_div(p, 16);
				lo += p[15:0];
			end
			lo += 64'd32768;
			hi += longint'(lo >> 16);
			res[32*r +: 32] = clamp32(hi);
		end
		expected_pos.insert(expected_pos.size(), res);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t make_load(input int b, input int e, input logic [31:0] v);
		item_t it;
		it = '{default: '0};
		it.func = FUNC_LOAD;
		it.bone = 6'(b);
		it.elem = 4'(e);
		it.value = v;
		it.px = $urandom;
		it.ids = 24'($urandom);
		it.wgt = {$urandom, $urandom};
		return it;
	endfunction

	function automatic item_t make_vertex(input bit wild);
		item_t it;
		it = '{default: '0};
		it.func = FUNC_SKIN;
		it.bone = 6'($urandom);
		it.elem = 4'($urandom);
		it.value = $urandom;
		if (wild) begin
			it.px = rand_word();
			it.py = rand_word();
			it.pz = rand_word();
		end else begin
			it.px = 32'($signed($urandom_range(0, 20)) - 10) <<< 14;
			it.py = 32'($signed($urandom_range(0, 20)) - 10) <<< 14;
			it.pz = $urandom;
		end
		it.ids = 24'($urandom);
		for (int n = 0; n < 4; n++) begin
			case ($urandom_range(0, 4))
				0: it.wgt[16*n +: 16] = 16'hFFFF;
				1: it.wgt[16*n +: 16] = 16'h0000;
				2: it.wgt[16*n +: 16] = 16'h4000;
				default: it.wgt[16*n +: 16] = 16'($urandom);
			endcase
		end
		return it;
	endfunction

	// Input driver: changes at the falling edge, transfer at the rising edge.
	always @(negedge clk) begin
		if (arst_n && s_tvalid && s_tready_q)
			void'(pending_items.pop_front());
		if (pending_items.size() > 0 &&
				((!in_hold && (!in_gaps || $urandom_range(0, 3) != 0)) ||
				(s_tvalid && !s_tready_q))) begin
			s_tvalid <= 1'b1;
			s_tuser <= pending_items[0].func;
			s_tdata <= IN_TDATA_W'({pending_items[0].wgt, pending_items[0].ids,
				pending_items[0].pz, pending_items[0].py, pending_items[0].px,
				pending_items[0].value, pending_items[0].elem, pending_items[0].bone});
		end else begin
			s_tvalid <= 1'b0;
		end
		if (out_hold)
			m_tready <= 1'b0;
		else if (out_stall)
			m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : 1'b0;
		else
			m_tready <= 1'b1;
	end

	// Sample the handshake at the rising edge; the driver consumes it next.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		s_tready_q <= s_tready;
		if (arst_n && s_tvalid && s_tready)
			skin_predict(pending_items[0]);
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pos.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected output %h", m_tdata);
			end else begin
				if (expected_pos[0] !== m_tdata) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %h got %h", expected_pos[0], m_tdata);
				end
				void'(expected_pos.pop_front());
				vertices_checked++;
			end
		end
	end

	// Backpressure mode changes now and then, plus rare long pauses on both sides.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			out_stall <= ~out_stall;
		if (out_hold)
			out_hold <= ($urandom_range(0, 15) != 0);
		else
			out_hold <= ($urandom_range(0, 299) == 0);
		if (in_hold)
			in_hold <= ($urandom_range(0, 15) != 0);
		else
			in_hold <= ($urandom_range(0, 299) == 0);
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_pos.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_bone_count(input logic [6:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		bones_used = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [6:0] counts [6];
		counts = '{7'd0, 7'd64, 7'd1, 7'd127, 7'd17, 7'd65};
		for (int i = 0; i < NBONES*16; i++)
			mat_store[i] = '0;
		bones_used = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: pass-through, extremes, loads beyond use, saturating blends.
		queue_item(make_vertex(1));
		queue_item(make_vertex(1));
		wait_drained();
		write_bone_count(7'd64);
		queue_item(make_vertex(1));
		for (int e = 0; e < 16; e++) begin
			queue_item(make_load(0, e, 32'h7FFF_FFFF));
			queue_item(make_load(63, e, 32'h8000_0000));
		end
		begin
			item_t v;
			v = make_vertex(1);
			v.ids = {6'd63, 6'd0, 6'd63, 6'd0};
			v.wgt = '1;
			queue_item(v);
			v.px = 32'h8000_0000; v.py = 32'h7FFF_FFFF; v.pz = 32'h8000_0000;
			v.wgt = '0;
			queue_item(v);
		end
		wait_drained();

		// Random phases over several bone counts.
		for (int ph = 0; ph < 6; ph++) begin
			write_bone_count(counts[ph]);
			in_gaps = (ph % 2 == 0);
			for (int i = 0; i < 290; i++) begin
				if ($urandom_range(0, 2) == 0) begin
					// Identity-like bones with random content keep sums in range.
					int b, e;
					b = $urandom_range(0, 63);
					e = $urandom_range(0, 15);
					queue_item(make_load(b, e,
						($urandom_range(0, 3) == 0) ? rand_word() :
						32'($signed($urandom_range(0, 8)) - 4) <<< 15));
				end else begin
					queue_item(make_vertex($urandom_range(0, 4) == 0));
				end
			end
			wait_drained();
		end

		$display("Checked %0d skinned vertices over six bone-count settings.",
			vertices_checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog.
	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("Timed out with %0d results outstanding.", expected_pos.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// File: filelist.f
src/lbs_pkg.sv
src/lbs_bone_store.sv
src/lbs_blend.sv
src/lbs_xform.sv
src/linear_blend_skinning.sv
src/lbs_checker.sv
test/tb.sv
